[rtl/finite_difference_derivatives_top_macros.svh]
// Assertion macros shared by the derivative block's modules.
`ifndef FINITE_DIFFERENCE_DERIVATIVES_TOP_MACROS_SVH
`define FINITE_DIFFERENCE_DERIVATIVES_TOP_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define FDD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define FDD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

[rtl/fdd_pkg.sv]
// Package: shared types and constants of the finite-difference derivative block.
`timescale 1ns / 1ps
package fdd_pkg;

   localparam int unsigned MAX_POINTS_DEFAULT = 4096;
   localparam int unsigned QUEUE_DEPTH        = 4;
   localparam int unsigned DATA_W             = 32;
   localparam int unsigned IDX_W              = 12;
   localparam int unsigned STATUS_W           = 2;
   localparam int unsigned CSR_IDX_W          = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_HALF_INV_SPACING = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_SPACING_SQ   = 4'd1;

   localparam logic [DATA_W-1:0] SCALE_RESET = 32'h0001_0000;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SHORT    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

   typedef enum logic [2:0] {
      JOB_HEAD,
      JOB_INTERIOR,
      JOB_TAIL,
      JOB_SHORT,
      JOB_OVERFLOW
   } job_kind_type;

   typedef enum logic [2:0] {
      ST_FORWARD,
      ST_CENTRAL_LO,
      ST_CENTRAL_HI,
      ST_BACKWARD,
      ST_ZERO
   } stencil_type;

   typedef struct packed {
      job_kind_type                  kind;
      logic [IDX_W-1:0]              base;
      logic [3:0][DATA_W-1:0]        win;
   } job_type;

endpackage

[rtl/fdd_ifs.sv]
// Interfaces: sample, result and register-write channels.
`timescale 1ns / 1ps
interface fdd_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [fdd_pkg::DATA_W-1:0]   sample;
   logic                                end_of_grid;
   modport source (output valid, sample, end_of_grid, input ready);
   modport sink   (input valid, sample, end_of_grid, output ready);
endinterface

interface fdd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [fdd_pkg::DATA_W-1:0]   first_deriv;
   logic signed [fdd_pkg::DATA_W-1:0]   second_deriv;
   logic [fdd_pkg::IDX_W-1:0]           point_index;
   logic                                last_point;
   logic [fdd_pkg::STATUS_W-1:0]        status;
   modport source (output valid, first_deriv, second_deriv, point_index, last_point, status,
                   input ready);
   modport sink   (input valid, first_deriv, second_deriv, point_index, last_point, status,
                   output ready);
endinterface

interface fdd_csr_if;
   logic                                valid;
   logic                                ready;
   logic [fdd_pkg::CSR_IDX_W-1:0]       reg_index;
   logic [fdd_pkg::DATA_W-1:0]          wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

[rtl/fdd_front.sv]
// Front end: sample window, point count and job classification.
`timescale 1ns / 1ps
`include "finite_difference_derivatives_top_macros.svh"
module fdd_front #(
   parameter int unsigned MAX_POINTS = fdd_pkg::MAX_POINTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   fdd_req_if.sink           req,
   input  logic              queue_full,
   output logic              push,
   output fdd_pkg::job_type  job
);
   localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
   localparam int unsigned EXT_W = (CNT_W > fdd_pkg::IDX_W) ? CNT_W : fdd_pkg::IDX_W;

   logic [CNT_W-1:0]                      count_ff, count_in;
   logic                                  overflow_ff, overflow_in;
   logic [3:0][fdd_pkg::DATA_W-1:0]       win_ff, win_in;
   logic                                  accept, at_cap, ovf_now;
   logic [EXT_W-1:0]                      count_ext;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign at_cap    = (count_ff == CNT_W'(MAX_POINTS));
   assign ovf_now   = overflow_ff || at_cap;
   assign count_ext = EXT_W'(count_ff);

   always_comb begin
      // Shift the new sample in unless the grid is full.
      if (at_cap) begin
         win_in = win_ff;
      end else begin
         win_in = {req.sample, win_ff[3], win_ff[2], win_ff[1]};
      end
      job.win  = win_in;
      job.base = fdd_pkg::IDX_W'(count_ext - EXT_W'(2));
      job.kind = fdd_pkg::JOB_INTERIOR;
      push     = 1'b0;
      count_in    = at_cap ? count_ff : count_ff + CNT_W'(1);
      overflow_in = ovf_now;
      if (req.end_of_grid) begin
         push        = accept;
         count_in    = '0;
         overflow_in = 1'b0;
         if (ovf_now) begin
            job.kind = fdd_pkg::JOB_OVERFLOW;
            job.base = '0;
         end else if (count_ff < CNT_W'(4)) begin
            job.kind = fdd_pkg::JOB_SHORT;
            job.base = '0;
         end else begin
            job.kind = fdd_pkg::JOB_TAIL;
         end
      end else if (!ovf_now) begin
         if (count_ff == CNT_W'(3)) begin
            push     = accept;
            job.kind = fdd_pkg::JOB_HEAD;
            job.base = '0;
         end else if (count_ff > CNT_W'(3)) begin
            push     = accept;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else if (accept) begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

   `FDD_ASSERT(a_count_in_range, count_ff <= CNT_W'(MAX_POINTS), "point count past capacity")
   `FDD_ASSERT(a_overflow_at_cap, overflow_ff |-> at_cap, "overflow flagged below capacity")
endmodule

[rtl/fdd_queue.sv]
// Job queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
`include "finite_difference_derivatives_top_macros.svh"
module fdd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fdd_pkg::job_type  push_job,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output fdd_pkg::job_type  head
);
   localparam int unsigned DEPTH = fdd_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   fdd_pkg::job_type    entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   `FDD_ASSERT(a_no_push_full, push |-> !full, "job pushed into full queue")
   `FDD_ASSERT(a_no_pop_empty, pop |-> !empty, "job popped from empty queue")
endmodule

[rtl/fdd_back.sv]
// Back end: stencil select, scaling multiplies, rounding and saturation.
`timescale 1ns / 1ps
`include "finite_difference_derivatives_top_macros.svh"
module fdd_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         empty,
   input  fdd_pkg::job_type             head,
   output logic                         pop,
   input  logic [fdd_pkg::DATA_W-1:0]   half_inv_spacing,
   input  logic [fdd_pkg::DATA_W-1:0]   inv_spacing_sq,
   fdd_rsp_if.source                    rsp
);
   localparam int unsigned NUM_W  = 36;
   localparam int unsigned HALF_W = 16;
   localparam int unsigned PROD_W = NUM_W + HALF_W;
   localparam int unsigned IDX_W  = fdd_pkg::IDX_W;
   localparam int unsigned DW     = fdd_pkg::DATA_W;

   function automatic logic [DW-1:0] round_sat(input logic [PROD_W-1:0] p_hi,
                                               input logic [PROD_W-1:0] p_lo,
                                               input logic neg);
      logic [PROD_W:0] lo_r;
      logic [PROD_W:0] q;
      logic [DW-1:0]   r;
      lo_r = ({1'b0, p_lo} + (PROD_W+1)'(32'h8000)) >> HALF_W;
      q    = {1'b0, p_hi} + lo_r;
      if (!neg) begin
         r = (q > (PROD_W+1)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[DW-1:0];
      end else if (q >= (PROD_W+1)'(32'h8000_0000)) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'd0 - q[DW-1:0];
      end
      return r;
   endfunction

   logic [1:0]                  sub_ff, sub_in;
   fdd_pkg::stencil_type        stencil;
   logic                        last_sub, last_pt, issue;
   logic [fdd_pkg::STATUS_W-1:0] status_sel;
   logic signed [NUM_W-1:0]     w0, w1, w2, w3, n1, n2;

   // stage A: magnitudes of the numerators
   logic                        a_valid_ff;
   logic [NUM_W-1:0]            a_m1_ff, a_m2_ff;
   logic                        a_neg1_ff, a_neg2_ff, a_last_ff;
   logic [IDX_W-1:0]            a_idx_ff;
   logic [fdd_pkg::STATUS_W-1:0] a_status_ff;
   // stage B: partial products
   logic                        b_valid_ff;
   logic [PROD_W-1:0]           b_p1hi_ff, b_p1lo_ff, b_p2hi_ff, b_p2lo_ff;
   logic                        b_neg1_ff, b_neg2_ff, b_last_ff;
   logic [IDX_W-1:0]            b_idx_ff;
   logic [fdd_pkg::STATUS_W-1:0] b_status_ff;
   // output register
   logic                        o_valid_ff;
   logic [DW-1:0]               o_fd_ff, o_sd_ff;
   logic [IDX_W-1:0]            o_idx_ff;
   logic                        o_last_ff;
   logic [fdd_pkg::STATUS_W-1:0] o_status_ff;

   logic out_free, b_free, a_free;

   assign out_free = !o_valid_ff || rsp.ready;
   assign b_free   = !b_valid_ff || out_free;
   assign a_free   = !a_valid_ff || b_free;
   assign issue    = !empty && a_free;
   assign pop      = issue && last_sub;

   always_comb begin
      stencil    = fdd_pkg::ST_ZERO;
      last_sub   = 1'b1;
      last_pt    = 1'b0;
      status_sel = fdd_pkg::STATUS_OK;
      case (head.kind)
         fdd_pkg::JOB_HEAD: begin
            stencil  = (sub_ff == 2'd0) ? fdd_pkg::ST_FORWARD : fdd_pkg::ST_CENTRAL_LO;
            last_sub = (sub_ff == 2'd1);
         end
         fdd_pkg::JOB_INTERIOR: begin
            stencil = fdd_pkg::ST_CENTRAL_LO;
         end
         fdd_pkg::JOB_TAIL: begin
            case (sub_ff)
               2'd0:    stencil = fdd_pkg::ST_CENTRAL_LO;
               2'd1:    stencil = fdd_pkg::ST_CENTRAL_HI;
               default: stencil = fdd_pkg::ST_BACKWARD;
            endcase
            last_sub = (sub_ff == 2'd2);
            last_pt  = (sub_ff == 2'd2);
         end
         fdd_pkg::JOB_SHORT: begin
            last_pt    = 1'b1;
            status_sel = fdd_pkg::STATUS_SHORT;
         end
         fdd_pkg::JOB_OVERFLOW: begin
            last_pt    = 1'b1;
            status_sel = fdd_pkg::STATUS_OVERFLOW;
         end
         default: begin
            last_pt = 1'b1;
         end
      endcase
   end

   always_comb begin
      w0 = NUM_W'(signed'(head.win[0]));
      w1 = NUM_W'(signed'(head.win[1]));
      w2 = NUM_W'(signed'(head.win[2]));
      w3 = NUM_W'(signed'(head.win[3]));
      case (stencil)
         fdd_pkg::ST_FORWARD: begin
            n1 = (w1 <<< 2) - w0 - (w0 <<< 1) - w2;
            n2 = (w0 <<< 1) - (w1 <<< 2) - w1 + (w2 <<< 2) - w3;
         end
         fdd_pkg::ST_CENTRAL_LO: begin
            n1 = w2 - w0;
            n2 = w0 - (w1 <<< 1) + w2;
         end
         fdd_pkg::ST_CENTRAL_HI: begin
            n1 = w3 - w1;
            n2 = w1 - (w2 <<< 1) + w3;
         end
         fdd_pkg::ST_BACKWARD: begin
            n1 = (w3 <<< 1) + w3 - (w2 <<< 2) + w1;
            n2 = (w3 <<< 1) - (w2 <<< 2) - w2 + (w1 <<< 2) - w0;
         end
         default: begin
            n1 = '0;
            n2 = '0;
         end
      endcase
   end

   always_comb begin
      sub_in = sub_ff;
      if (pop) begin
         sub_in = 2'd0;
      end else if (issue) begin
         sub_in = sub_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff     <= 2'd0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         sub_ff <= sub_in;
         if (a_free) begin
            a_valid_ff <= issue;
         end
         if (b_free) begin
            b_valid_ff <= a_valid_ff;
         end
         if (out_free) begin
            o_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         a_neg1_ff   <= n1[NUM_W-1];
         a_neg2_ff   <= n2[NUM_W-1];
         a_m1_ff     <= n1[NUM_W-1] ? NUM_W'(-n1) : NUM_W'(n1);
         a_m2_ff     <= n2[NUM_W-1] ? NUM_W'(-n2) : NUM_W'(n2);
         a_idx_ff    <= head.base + IDX_W'(sub_ff);
         a_last_ff   <= last_pt;
         a_status_ff <= status_sel;
      end
      if (b_free && a_valid_ff) begin
         b_p1hi_ff   <= PROD_W'(a_m1_ff) * PROD_W'(half_inv_spacing[DW-1:HALF_W]);
         b_p1lo_ff   <= PROD_W'(a_m1_ff) * PROD_W'(half_inv_spacing[HALF_W-1:0]);
         b_p2hi_ff   <= PROD_W'(a_m2_ff) * PROD_W'(inv_spacing_sq[DW-1:HALF_W]);
         b_p2lo_ff   <= PROD_W'(a_m2_ff) * PROD_W'(inv_spacing_sq[HALF_W-1:0]);
         b_neg1_ff   <= a_neg1_ff;
         b_neg2_ff   <= a_neg2_ff;
         b_idx_ff    <= a_idx_ff;
         b_last_ff   <= a_last_ff;
         b_status_ff <= a_status_ff;
      end
      if (out_free && b_valid_ff) begin
         o_fd_ff     <= round_sat(b_p1hi_ff, b_p1lo_ff, b_neg1_ff);
         o_sd_ff     <= round_sat(b_p2hi_ff, b_p2lo_ff, b_neg2_ff);
         o_idx_ff    <= b_idx_ff;
         o_last_ff   <= b_last_ff;
         o_status_ff <= b_status_ff;
      end
   end

   assign rsp.valid        = o_valid_ff;
   assign rsp.first_deriv  = signed'(o_fd_ff);
   assign rsp.second_deriv = signed'(o_sd_ff);
   assign rsp.point_index  = o_idx_ff;
   assign rsp.last_point   = o_last_ff;
   assign rsp.status       = o_status_ff;

   `FDD_ASSERT(a_error_is_last, (o_valid_ff && (o_status_ff != fdd_pkg::STATUS_OK)) |-> o_last_ff, "error result not marked last")
   `FDD_ASSERT(a_sub_bounded, sub_ff != 2'd3, "result sequencer out of range")
endmodule

[rtl/finite_difference_derivatives_top.sv]
// Top level: finite-difference derivative stream block with its scale registers.
//
// Usage:
//  req_chan carries grid samples (signed Q16.16) with end_of_grid on the final
//  sample; rsp_chan returns first and second derivatives per point, in point
//  order, with point_index, last_point and status. csr_chan writes the scale
//  registers (index 0: 1/(2h), index 1: 1/h^2, both unsigned Q16.16); it is
//  always ready and must only be written while no grid is in flight.
//  A result caused by a sample is registered in turn in the job queue, the
//  numerator stage, the multiply stage and the output register.
//  Throughput: one sample per cycle unless the job queue is full; the result
//  side gives one result per cycle while rsp_chan is ready, so while the three
//  results of a final sample go out, the four-entry job queue absorbs samples.
//  Reset clears the point count, overflow flag, queue and pipeline and sets
//  both scales to 1.0. When the receiver stalls, the output register holds,
//  the pipeline backs up into the queue, and req_chan.ready drops only once
//  the queue is full.
`timescale 1ns / 1ps
module finite_difference_derivatives_top #(
   parameter int unsigned MAX_POINTS = fdd_pkg::MAX_POINTS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   fdd_req_if.sink   req_chan,
   fdd_rsp_if.source rsp_chan,
   fdd_csr_if.sink   csr_chan
);
   // scale registers
   logic [fdd_pkg::DATA_W-1:0] half_inv_spacing_ff;
   logic [fdd_pkg::DATA_W-1:0] inv_spacing_sq_ff;
   logic                       csr_write;

   // front to queue, queue to back
   logic             push, queue_full, queue_empty, pop;
   fdd_pkg::job_type push_job, head_job;

   // take every register write at once; unknown indexes are ignored
   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_inv_spacing_ff <= fdd_pkg::SCALE_RESET;
         inv_spacing_sq_ff   <= fdd_pkg::SCALE_RESET;
      end else if (csr_write) begin
         case (csr_chan.reg_index)
            fdd_pkg::CSR_HALF_INV_SPACING: half_inv_spacing_ff <= csr_chan.wdata;
            fdd_pkg::CSR_INV_SPACING_SQ:   inv_spacing_sq_ff   <= csr_chan.wdata;
            default: begin
            end
         endcase
      end
   end

   // classify each sample into a job for the back end
   fdd_front #(
      .MAX_POINTS (MAX_POINTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .job        (push_job)
   );

   // decouple sample acceptance from result delivery
   fdd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .head     (head_job)
   );

   // expand jobs into results and scale them
   fdd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .empty            (queue_empty),
      .head             (head_job),
      .pop              (pop),
      .half_inv_spacing (half_inv_spacing_ff),
      .inv_spacing_sq   (inv_spacing_sq_ff),
      .rsp              (rsp_chan)
   );
endmodule

[sim/finite_difference_derivatives_top_tb.sv]
// Testbench: streams sample grids through the derivative block and scoreboards every result.
`timescale 1ns / 1ps
module finite_difference_derivatives_top_tb;

   localparam int unsigned MAX_POINTS       = fdd_pkg::MAX_POINTS_DEFAULT;
   localparam int          CLK_PERIOD       = 20;
   localparam int          RESET_CYCLES     = 3;
   // Leave margin between the last result and a register write.
   localparam int          SETTLE_CYCLES    = 8;
   localparam int          LONG_HOLD_CYCLES = 60;
   localparam int          MAX_GAP          = 6;
   localparam longint      TIMEOUT_NS       = 64'd2_000_000;
   localparam logic [fdd_pkg::CSR_IDX_W-1:0] UNUSED_CSR_IDX = 4'hF;
   localparam logic [fdd_pkg::DATA_W-1:0]    HALF_UNIT      = 32'h0000_8000;

   typedef struct packed {
      logic signed [fdd_pkg::DATA_W-1:0] first_deriv;
      logic signed [fdd_pkg::DATA_W-1:0] second_deriv;
      logic [fdd_pkg::IDX_W-1:0]         point_index;
      logic                              last_point;
      logic [fdd_pkg::STATUS_W-1:0]      status;
   } point_result_type;

   typedef struct packed {
      logic signed [fdd_pkg::DATA_W-1:0] sample;
      logic                              end_of_grid;
      logic                              typed;
      point_result_type                  typed_result;
   } stim_row_type;

   typedef enum int {SMALL_VALUES, FULL_RANGE, EXTREMES, SMOOTH_RAMP} sample_style_type;

   localparam point_result_type NO_RESULT  = '0;
   localparam point_result_type SHORT_GRID = '{first_deriv: '0, second_deriv: '0,
                                               point_index: '0, last_point: 1'b1,
                                               status: fdd_pkg::STATUS_SHORT};

   // Directed stimulus, walked in order right after reset (both scales at 1.0).
   // Only the too-short grid results are typed in; all other rows use the predictor.
   localparam stim_row_type DIRECTED_ROWS [0:17] = '{
      // lone sample that ends its grid: too short
      '{32'sh7FFF_FFFF, 1'b1, 1'b1, SHORT_GRID},
      // two-sample grid
      '{32'sh8000_0000, 1'b0, 1'b0, NO_RESULT},
      '{32'sh0000_0001, 1'b1, 1'b1, SHORT_GRID},
      // four-sample grid: all four points would fall due at once, so it is too short
      '{32'sh0000_0000, 1'b0, 1'b0, NO_RESULT},
      '{32'sh0001_0000, 1'b0, 1'b0, NO_RESULT},
      '{32'sh0002_0000, 1'b0, 1'b0, NO_RESULT},
      '{32'shFFFF_FFFF, 1'b1, 1'b1, SHORT_GRID},
      // shortest full grid, alternating extremes: second derivatives saturate, first ones only at the ends
      '{32'sh7FFF_FFFF, 1'b0, 1'b0, NO_RESULT},
      '{32'sh8000_0000, 1'b0, 1'b0, NO_RESULT},
      '{32'sh7FFF_FFFF, 1'b0, 1'b0, NO_RESULT},
      '{32'sh8000_0000, 1'b0, 1'b0, NO_RESULT},
      '{32'sh7FFF_FFFF, 1'b1, 1'b0, NO_RESULT},
      // x^2 on a unit grid: four central-difference points plus both end stencils
      '{32'sh0000_0000, 1'b0, 1'b0, NO_RESULT},
      '{32'sh0001_0000, 1'b0, 1'b0, NO_RESULT},
      '{32'sh0004_0000, 1'b0, 1'b0, NO_RESULT},
      '{32'sh0009_0000, 1'b0, 1'b0, NO_RESULT},
      '{32'sh0010_0000, 1'b0, 1'b0, NO_RESULT},
      '{32'sh0019_0000, 1'b1, 1'b0, NO_RESULT}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   fdd_req_if req_chan ();
   fdd_rsp_if rsp_chan ();
   fdd_csr_if csr_chan ();

   finite_difference_derivatives_top #(
      .MAX_POINTS (MAX_POINTS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Predictor state: its own copy of the scales, the sample window and the grid counters.
   logic [fdd_pkg::DATA_W-1:0] half_scale = fdd_pkg::SCALE_RESET;
   logic [fdd_pkg::DATA_W-1:0] sq_scale   = fdd_pkg::SCALE_RESET;
   longint                     grid_win [0:3] = '{default: 0};
   int unsigned                pts_taken = 0;
   bit                         cap_exceeded = 1'b0;
   point_result_type           due_points [0:2];

   // Expected results in point order, and how many are still owed.
   point_result_type derivs_due [$];
   int               points_owed = 0;

   int  mismatches = 0;
   int  results_checked = 0;
   int  samples_sent = 0;
   int  grids_done = 0;
   int  scale_sets = 1;
   int  input_stall_cycles = 0;
   bit  long_hold_armed = 1'b0;

   // Multiply a stencil numerator by an unsigned Q16.16 scale, round half away
   // from zero, and clamp to the signed 32-bit range.
   function automatic logic [fdd_pkg::DATA_W-1:0] scale_round_sat(
         input longint num, input logic [fdd_pkg::DATA_W-1:0] scale);
      longint unsigned mag;
      longint unsigned q;
      mag = (num < 0) ? -num : num;
      q = mag * scale[31:16] + ((mag * scale[15:0] + 64'h8000) >> 16);
      if (num >= 0)
         return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      if (q >= 64'h8000_0000)
         return 32'h8000_0000;
      return ~q[31:0] + 32'd1;
   endfunction

   function automatic point_result_type make_point(input longint d1, input longint d2,
                                                   input int unsigned idx, input logic last);
      point_result_type r;
      r.first_deriv  = scale_round_sat(d1, half_scale);
      r.second_deriv = scale_round_sat(d2, sq_scale);
      r.point_index  = idx[fdd_pkg::IDX_W-1:0];
      r.last_point   = last;
      r.status       = fdd_pkg::STATUS_OK;
      return r;
   endfunction

   function automatic point_result_type grid_error(input logic [fdd_pkg::STATUS_W-1:0] code);
      point_result_type r;
      r = '0;
      r.last_point = 1'b1;
      r.status     = code;
      return r;
   endfunction

   // Advance the predicted grid by one sample; fill due_points and return how many fell due.
   function automatic int advance_grid(input logic signed [fdd_pkg::DATA_W-1:0] s,
                                       input logic eog);
      int unsigned c;
      int          n;
      c = pts_taken;
      n = 0;
      if (pts_taken >= MAX_POINTS) begin
         cap_exceeded = 1'b1;
      end else begin
         grid_win[0] = grid_win[1];
         grid_win[1] = grid_win[2];
         grid_win[2] = grid_win[3];
         grid_win[3] = longint'(s);
         pts_taken++;
      end
      if (eog) begin
         if (cap_exceeded) begin
            due_points[0] = grid_error(fdd_pkg::STATUS_OVERFLOW);
            n = 1;
         end else if (c < 4) begin
            due_points[0] = grid_error(fdd_pkg::STATUS_SHORT);
            n = 1;
         end else begin
            due_points[0] = make_point(grid_win[2] - grid_win[0],
                                       grid_win[0] - 2 * grid_win[1] + grid_win[2], c - 2, 1'b0);
            due_points[1] = make_point(grid_win[3] - grid_win[1],
                                       grid_win[1] - 2 * grid_win[2] + grid_win[3], c - 1, 1'b0);
            due_points[2] = make_point(3 * grid_win[3] - 4 * grid_win[2] + grid_win[1],
                                       2 * grid_win[3] - 5 * grid_win[2] + 4 * grid_win[1]
                                       - grid_win[0], c, 1'b1);
            n = 3;
         end
         grid_win     = '{default: 0};
         pts_taken    = 0;
         cap_exceeded = 1'b0;
      end else if (!cap_exceeded && c == 3) begin
         due_points[0] = make_point(-3 * grid_win[0] + 4 * grid_win[1] - grid_win[2],
                                    2 * grid_win[0] - 5 * grid_win[1] + 4 * grid_win[2]
                                    - grid_win[3], 0, 1'b0);
         due_points[1] = make_point(grid_win[2] - grid_win[0],
                                    grid_win[0] - 2 * grid_win[1] + grid_win[2], 1, 1'b0);
         n = 2;
      end else if (!cap_exceeded && c > 3) begin
         due_points[0] = make_point(grid_win[2] - grid_win[0],
                                    grid_win[0] - 2 * grid_win[1] + grid_win[2], c - 2, 1'b0);
         n = 1;
      end
      return n;
   endfunction

   function automatic logic signed [fdd_pkg::DATA_W-1:0] pick_sample(
         input sample_style_type style, input logic signed [fdd_pkg::DATA_W-1:0] prev);
      logic signed [fdd_pkg::DATA_W-1:0] v;
      case (style)
         SMALL_VALUES: v = $signed($urandom_range(0, 'h6_0000)) - 32'sh3_0000;
         FULL_RANGE:   v = $urandom;
         EXTREMES: begin
            case ($urandom_range(0, 4))
               0:       v = 32'sh7FFF_FFFF;
               1:       v = 32'sh8000_0000;
               2:       v = 32'sh0000_0000;
               3:       v = 32'shFFFF_FFFF;
               default: v = $urandom;
            endcase
         end
         default:      v = prev + $signed($urandom_range(0, 'h2_0000)) - 32'sh1_0000;
      endcase
      return v;
   endfunction

   // Offer one sample, wait for its transaction, queue what it should produce,
   // then idle for a drawn number of cycles unless running back to back.
   task automatic send_sample(input logic signed [fdd_pkg::DATA_W-1:0] s, input logic eog,
                              input bit back_to_back, input bit typed = 1'b0,
                              input point_result_type typed_res = '0);
      int n;
      int i;
      int gap;
      req_chan.valid       <= 1'b1;
      req_chan.sample      <= s;
      req_chan.end_of_grid <= eog;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      n = advance_grid(s, eog);
      if (typed) begin
         derivs_due.push_back(typed_res);
         points_owed++;
      end else begin
         for (i = 0; i < n; i++) begin
            derivs_due.push_back(due_points[i]);
            points_owed++;
         end
      end
      samples_sent++;
      if (eog)
         grids_done++;
      gap = back_to_back ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and hold until every expected result has come back.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      wait (points_owed == 0);
      @(posedge clock);
   endtask

   task automatic write_csr(input logic [fdd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [fdd_pkg::DATA_W-1:0] data);
      csr_chan.valid     <= 1'b1;
      csr_chan.reg_index <= idx;
      csr_chan.wdata     <= data;
      do @(posedge clock); while (!(csr_chan.valid && csr_chan.ready));
      if (idx == fdd_pkg::CSR_HALF_INV_SPACING)
         half_scale = data;
      else if (idx == fdd_pkg::CSR_INV_SPACING_SQ)
         sq_scale = data;
   endtask

   // Reprogram both scales once the block is idle; optionally poke an unmapped index.
   task automatic apply_scales(input logic [fdd_pkg::DATA_W-1:0] half,
                               input logic [fdd_pkg::DATA_W-1:0] sq,
                               input bit poke_unused);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(fdd_pkg::CSR_HALF_INV_SPACING, half);
      write_csr(fdd_pkg::CSR_INV_SPACING_SQ, sq);
      if (poke_unused)
         write_csr(UNUSED_CSR_IDX, $urandom);
      csr_chan.valid <= 1'b0;
      scale_sets++;
   endtask

   // Random grids until about item_goal samples went in. Mostly full grids,
   // some too short, some long; now and then pause mid-grid until drained.
   task automatic run_grids(input int item_goal);
      int                                sent;
      int                                len;
      int                                k;
      bit                                back_to_back;
      sample_style_type                  style;
      logic signed [fdd_pkg::DATA_W-1:0] s;
      logic                              eog;
      sent = 0;
      s = '0;
      while (sent < item_goal) begin
         case ($urandom_range(0, 9))
            0, 1:    len = $urandom_range(1, 4);
            2:       len = $urandom_range(17, 40);
            default: len = $urandom_range(5, 16);
         endcase
         back_to_back = ($urandom_range(0, 3) == 0);
         style = sample_style_type'($urandom_range(0, 3));
         for (k = 0; k < len; k++) begin
            s = pick_sample(style, s);
            eog = (k == len - 1);
            send_sample(s, eog, back_to_back);
            if (!eog && $urandom_range(0, 39) == 0)
               drain_results();
         end
         sent += len;
      end
   endtask

   // Result side: draw a stall before each transaction, sometimes run with none,
   // and take one long hold-off when asked.
   initial begin : result_sink
      int stall;
      bit no_stall;
      no_stall = 1'b0;
      rsp_chan.ready <= 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0)
            no_stall = !no_stall;
         if (long_hold_armed) begin
            long_hold_armed = 1'b0;
            stall = LONG_HOLD_CYCLES;
         end else begin
            stall = no_stall ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
      end
   end

   // Scoreboard: compare each result transaction with the oldest expectation.
   always @(posedge clock) begin
      point_result_type got;
      point_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.first_deriv, rsp_chan.second_deriv, rsp_chan.point_index,
                 rsp_chan.last_point, rsp_chan.status};
         if (derivs_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result: first %h second %h index %0d last %b status %0d",
                     $time, got.first_deriv, got.second_deriv, got.point_index,
                     got.last_point, got.status);
         end else begin
            want = derivs_due.pop_front();
            points_owed--;
            results_checked++;
            if (got !== want) begin
               mismatches++;
               $display("%0t: expected first %h second %h index %0d last %b status %0d",
                        $time, want.first_deriv, want.second_deriv, want.point_index,
                        want.last_point, want.status);
               $display("%0t:   actual first %h second %h index %0d last %b status %0d",
                        $time, got.first_deriv, got.second_deriv, got.point_index,
                        got.last_point, got.status);
            end
         end
      end
      if (!reset && req_chan.valid && !req_chan.ready)
         input_stall_cycles++;
   end

   // Stimulus: directed rows, then random grids under several scale settings
   // and a back-pressure burst against a long result stall.
   initial begin : stimulus
      int                                r;
      int                                k;
      logic signed [fdd_pkg::DATA_W-1:0] s;

      req_chan.valid       <= 1'b0;
      req_chan.sample      <= '0;
      req_chan.end_of_grid <= 1'b0;
      csr_chan.valid       <= 1'b0;
      csr_chan.reg_index   <= '0;
      csr_chan.wdata       <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed rows at the reset scales.
      for (r = 0; r < $size(DIRECTED_ROWS); r++)
         send_sample(DIRECTED_ROWS[r].sample, DIRECTED_ROWS[r].end_of_grid, 1'b0,
                     DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].typed_result);

      // Zero scales: every derivative collapses to zero.
      apply_scales('0, '0, 1'b0);
      run_grids(40);

      // Largest scales: nearly everything saturates.
      apply_scales('1, '1, 1'b0);
      run_grids(40);

      // Unit spacing with a random curvature scale; ties in rounding appear here.
      apply_scales(HALF_UNIT, $urandom_range(0, 'h4_0000), 1'b0);
      run_grids(30);
      // Stall the result side for a long stretch while samples keep coming back to back.
      long_hold_armed = 1'b1;
      s = '0;
      for (k = 0; k < 40; k++) begin
         s = pick_sample(SMALL_VALUES, s);
         send_sample(s, k == 39, 1'b1);
      end
      run_grids(30);

      // Arbitrary scales, plus a write to an unmapped index that must change nothing.
      apply_scales($urandom, $urandom, 1'b1);
      run_grids(50);

      apply_scales($urandom_range(0, 'h2_0000), $urandom_range(0, 'h2_0000), 1'b0);
      run_grids(40);

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d grids, %0d samples, %0d results checked, %0d scale settings;",
               grids_done, samples_sent, results_checked, scale_sets);
      $display("short grids, zero and saturating scales and a long result stall, %0d %s",
               input_stall_cycles, "input stall cycles.");
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("%0t: timed out with %0d results outstanding", $time, points_owed);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
